[hdl/apqc_pkg.sv]
// Shared types and constants for the aging priority queue with cancel.
`default_nettype none

package apqc_pkg;

    // Field widths fixed by the item format
    localparam int OPCODE_W = 2;
    localparam int TIME_W   = 30;
    localparam int NAME_W   = 64;
    localparam int SEV_W    = 20;
    localparam int STATUS_W = 2;
    localparam int WEIGHT_W = 24;
    localparam int PROD_W   = WEIGHT_W + TIME_W;
    // Key spans -(2^54) .. 2^20, so 56 signed bits hold it exactly
    localparam int KEY_W    = PROD_W + 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ARRIVE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SERVE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LEAVE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SERVED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_AGING_WEIGHT = 1'b0;
    localparam logic [WEIGHT_W-1:0] AGING_WEIGHT_RESET = 24'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic                in_ready;
        logic                load;
        logic                scan_start;
        logic                scan_issue;
        logic                eval;
        logic                wr_clear;
        logic                wr_arrive;
        logic                wr_leave;
        logic                wr_serve;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } apqc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                full;
        logic                empty;
        logic                issue_left;
        logic                clear_last;
        logic                hit;
        logic                last;
        logic                out_free;
    } apqc_stat_t;

endpackage

`default_nettype wire

[hdl/apqc_in_if.sv]
// Request channel: one queue operation per beat.
`default_nettype none

interface apqc_in_if;
    logic                              valid;
    logic                              ready;
    logic [apqc_pkg::OPCODE_W-1:0]     opcode;
    logic [apqc_pkg::TIME_W-1:0]       arrival_time;
    logic [apqc_pkg::NAME_W-1:0]       patient_name;
    logic [apqc_pkg::SEV_W-1:0]        severity;

    modport source (output valid, output opcode, output arrival_time,
                    output patient_name, output severity, input ready);
    modport sink   (input valid, input opcode, input arrival_time,
                    input patient_name, input severity, output ready);
endinterface

`default_nettype wire

[hdl/apqc_out_if.sv]
// Response channel: one result per beat.
`default_nettype none

interface apqc_out_if;
    logic                              valid;
    logic                              ready;
    logic [apqc_pkg::STATUS_W-1:0]     status;
    logic [apqc_pkg::NAME_W-1:0]       served_name;

    modport source (output valid, output status, output served_name, input ready);
    modport sink   (input valid, input status, input served_name, output ready);
endinterface

`default_nettype wire

[hdl/apqc_ctrl.sv]
// Controller state machine: clear pass, dispatch, scan and result sequencing.
`default_nettype none

module apqc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire apqc_pkg::apqc_stat_t   stat,
    output apqc_pkg::apqc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SERVE_WR,
        S_RESULT
    } state_t;

    state_t                            state_reg, state_next;
    logic [apqc_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;

    // State and registered result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            res_status_reg <= apqc_pkg::ST_SERVED;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd             = '0;
        cmd.res_status  = res_status_reg;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_clear = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.scan_start = 1'b1;
                case (stat.op)
                    apqc_pkg::OP_ARRIVE:
                    begin
                        if (stat.full)
                        begin
                            res_status_next = apqc_pkg::ST_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    apqc_pkg::OP_SERVE:
                    begin
                        if (stat.empty)
                        begin
                            res_status_next = apqc_pkg::ST_EMPTY;
                            state_next      = S_RESULT;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    apqc_pkg::OP_LEAVE:
                    begin
                        state_next = stat.empty ? S_IDLE : S_SCAN;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_issue = stat.issue_left;
                cmd.eval       = 1'b1;
                case (stat.op)
                    apqc_pkg::OP_ARRIVE:
                    begin
                        // first free slot takes the entry
                        if (stat.hit)
                        begin
                            cmd.wr_arrive = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    apqc_pkg::OP_LEAVE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.wr_leave = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else if (stat.last)
                            state_next = S_IDLE;
                    end
                    apqc_pkg::OP_SERVE:
                    begin
                        if (stat.last)
                        begin
                            res_status_next = apqc_pkg::ST_SERVED;
                            state_next      = S_SERVE_WR;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SERVE_WR:
            begin
                cmd.wr_serve = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                // wait for the output register to free up
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hdl/apqc_dp.sv]
// Datapath: entry memory, key multiplier, scan pipeline, best tracker, output register.
`default_nettype none

module apqc_dp #(
    parameter int CAPACITY   = 64,
    parameter int NAME_BYTES = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire apqc_pkg::apqc_cmd_t               cmd,
    output apqc_pkg::apqc_stat_t                   stat,
    input  wire logic [apqc_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [apqc_pkg::TIME_W-1:0]       arrival_time,
    input  wire logic [apqc_pkg::NAME_W-1:0]       patient_name,
    input  wire logic [apqc_pkg::SEV_W-1:0]        severity,
    input  wire logic [apqc_pkg::WEIGHT_W-1:0]     aging_weight,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [apqc_pkg::STATUS_W-1:0]          out_status,
    output logic [apqc_pkg::NAME_W-1:0]            out_name
);

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int SNAME_W = 8 * NAME_BYTES;
    localparam int KEY_W   = apqc_pkg::KEY_W;
    localparam int MEM_W   = 1 + KEY_W + SNAME_W;

    // Latched request
    logic [apqc_pkg::OPCODE_W-1:0] op_reg;
    logic [apqc_pkg::TIME_W-1:0]   time_reg;
    logic [SNAME_W-1:0]            name_reg;
    logic [apqc_pkg::SEV_W-1:0]    sev_reg;
    logic [apqc_pkg::PROD_W-1:0]   prod_reg;
    logic [KEY_W-1:0]              new_key;

    // Entry memory: {valid, key, name}
    logic [MEM_W-1:0]   mem [CAPACITY];
    logic [MEM_W-1:0]   rd_word_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic               rd_vld_reg;
    logic [CNT_W-1:0]   issue_cnt_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [MEM_W-1:0]   wr_data;

    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [SNAME_W-1:0] rd_name;

    // Best candidate for serve
    logic               best_found_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [SNAME_W-1:0] best_name_reg;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic               ranks_above;
    logic               best_take;

    logic [CNT_W-1:0]   cnt_reg;

    logic                          out_valid_reg;
    logic [apqc_pkg::STATUS_W-1:0] out_status_reg;
    logic [apqc_pkg::NAME_W-1:0]   out_name_reg;

    // Request latch; bytes past NAME_BYTES are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            time_reg <= arrival_time;
            name_reg <= patient_name[apqc_pkg::NAME_W-1 -: SNAME_W];
            sev_reg  <= severity;
        end
    end

    // Aging product, registered before the subtract
    always_ff @(posedge clk)
    begin
        prod_reg <= apqc_pkg::PROD_W'(aging_weight) * apqc_pkg::PROD_W'(time_reg);
    end

    assign new_key = KEY_W'(sev_reg) - KEY_W'(prod_reg);

    // Memory word fields
    assign rd_valid = rd_word_reg[MEM_W-1];
    assign rd_key   = rd_word_reg[SNAME_W +: KEY_W];
    assign rd_name  = rd_word_reg[SNAME_W-1:0];

    // Write port select
    always_comb
    begin
        wr_en   = cmd.wr_clear | cmd.wr_arrive | cmd.wr_leave | cmd.wr_serve;
        wr_addr = rd_idx_reg;
        wr_data = '0;
        if (cmd.wr_clear)
            wr_addr = issue_cnt_reg[ADDR_W-1:0];
        else if (cmd.wr_serve)
            wr_addr = best_idx_reg;
        if (cmd.wr_arrive)
            wr_data = {1'b1, new_key, name_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= mem[issue_cnt_reg[ADDR_W-1:0]];
        rd_idx_reg  <= issue_cnt_reg[ADDR_W-1:0];
    end

    // Scan / clear address counter and read pipeline valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.scan_start)
                issue_cnt_reg <= '0;
            else if (cmd.scan_issue || cmd.wr_clear)
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
        end
    end

    // Priority compare: higher key wins, then smaller name
    always_comb
    begin
        if (rd_key != best_key_reg)
            ranks_above = $signed(rd_key) > $signed(best_key_reg);
        else
            ranks_above = rd_name < best_name_reg;
        best_take = cmd.eval && rd_vld_reg && rd_valid && (op_reg == apqc_pkg::OP_SERVE)
                    && (!best_found_reg || ranks_above);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_found_reg <= 1'b0;
        else if (cmd.scan_start)
            best_found_reg <= 1'b0;
        else if (best_take)
            best_found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (best_take)
        begin
            best_key_reg  <= rd_key;
            best_name_reg <= rd_name;
            best_idx_reg  <= rd_idx_reg;
        end
    end

    // Occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.wr_arrive)
            cnt_reg <= cnt_reg + CNT_W'(1);
        else if (cmd.wr_leave || cmd.wr_serve)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            if (cmd.res_status == apqc_pkg::ST_SERVED)
                out_name_reg <= apqc_pkg::NAME_W'(best_name_reg)
                                << (apqc_pkg::NAME_W - SNAME_W);
            else
                out_name_reg <= '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_name   = out_name_reg;

    // Status to controller
    always_comb
    begin
        stat            = '0;
        stat.op         = op_reg;
        stat.full       = cnt_reg == CNT_W'(CAPACITY);
        stat.empty      = cnt_reg == '0;
        stat.issue_left = issue_cnt_reg != CNT_W'(CAPACITY);
        stat.clear_last = issue_cnt_reg == CNT_W'(CAPACITY - 1);
        stat.last       = rd_vld_reg && (rd_idx_reg == ADDR_W'(CAPACITY - 1));
        stat.out_free   = !out_valid_reg || out_ready;
        case (op_reg)
            apqc_pkg::OP_ARRIVE: stat.hit = rd_vld_reg && !rd_valid;
            apqc_pkg::OP_LEAVE:  stat.hit = rd_vld_reg && rd_valid && (rd_name == name_reg);
            default:             stat.hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/aging_priority_queue_with_cancel_core.sv]
// Top level: aging priority queue with cancel, APB register and channel wiring.
//
// Usage: each beat on the request channel carries one operation: arrive stores
// a name with key severity - aging_weight * arrival_time, serve removes and
// returns the entry with the greatest key (smaller name wins a tie), leave
// removes the named entry. Serve always gives one response beat (served or
// empty); arrive gives one only when the queue is full and the item is
// dropped; leave never gives one.
// Timing: arrive, leave and serve walk the entry memory through its single
// read port, one entry per cycle, but for an arrive into a full queue and a
// serve or leave on an empty one. Arrive is back in idle once the scan finds
// a free slot, leave once it finds the name or passes the last entry; serve
// writes back the removed slot, then loads its response; a full arrive or an
// empty serve loads its response straight after dispatch. One request is
// worked on at a time; the next is taken once the block is back in idle,
// even while the last response still sits in the output register.
// Reset: aging_weight returns to 1 and a clearing pass over every entry
// empties the memory; no request is taken until it ends, APB writes are.
// Stall: a new result waits in the controller while a response is held, and
// no request is taken until it moves into the output register.
`default_nettype none

module aging_priority_queue_with_cancel_core #(
    parameter int CAPACITY   = 64,
    parameter int NAME_BYTES = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [apqc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [apqc_pkg::PDATA_W-1:0]  pwdata,
    output logic [apqc_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    apqc_in_if.sink                            request,
    apqc_out_if.source                         response
);

    apqc_pkg::apqc_cmd_t   cmd;
    apqc_pkg::apqc_stat_t  stat;
    logic [apqc_pkg::WEIGHT_W-1:0] aging_weight_reg;
    logic                  cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == apqc_pkg::REG_AGING_WEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            aging_weight_reg <= apqc_pkg::AGING_WEIGHT_RESET;
        else if (cfg_wr)
            aging_weight_reg <= pwdata[apqc_pkg::WEIGHT_W-1:0];
    end

    assign prdata = (paddr[2] == apqc_pkg::REG_AGING_WEIGHT)
                    ? apqc_pkg::PDATA_W'(aging_weight_reg) : '0;

    assign request.ready = cmd.in_ready;

    apqc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    apqc_dp #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (request.opcode),
        .arrival_time (request.arrival_time),
        .patient_name (request.patient_name),
        .severity     (request.severity),
        .aging_weight (aging_weight_reg),
        .out_ready    (response.ready),
        .out_valid    (response.valid),
        .out_status   (response.status),
        .out_name     (response.served_name)
    );

    // At most one memory write source per cycle
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_clear, cmd.wr_arrive, cmd.wr_leave, cmd.wr_serve}))
        else $error("several memory write commands at once");

    // An arrive is never stored into a full queue
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_arrive |-> !stat.full)
        else $error("arrive stored while queue full");

    // A result never overwrites an undelivered one
    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.out_free)
        else $error("result loaded over a pending response");

    // A request beat is never taken while a scan is running
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |-> !cmd.scan_issue)
        else $error("request accepted during scan");

endmodule

`default_nettype wire
